// ===== rtl/core/rbe_pkg.sv =====
// ----------------------------------------------------------------------------
// rANS byte encoder package
// Shared widths, action codes, beat types and controller interface structs.
// ----------------------------------------------------------------------------
package rbe_pkg;

   localparam int SCALE_BITS  = 12;
   localparam int ALPHABET    = 256;

   localparam int STATE_W     = 32;
   localparam int FREQ_W      = 13;
   localparam int START_W     = 12;
   localparam int SYM_W       = 8;
   localparam int BYTE_W      = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int REM_W       = FREQ_W + 1;
   localparam int DIV_STEPS   = STATE_W;
   localparam int CNT_W       = $clog2(DIV_STEPS);
   localparam int FIN_BYTES   = STATE_W / BYTE_W;
   localparam int FIN_W       = $clog2(FIN_BYTES);
   localparam int BOUND_SHIFT = 31 - SCALE_BITS;
   localparam int CMP_W       = STATE_W + FREQ_W;
   localparam int SYM_CMP_W   = SYM_W + 1;
   localparam int ENTRY_W     = FREQ_W + START_W;

   localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(1) << 23;

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_ENCODE = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [SYM_W-1:0]   symbol;
      logic [FREQ_W-1:0]  frequency;
      logic [START_W-1:0] start_req;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              status;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic table_write;
      logic latch_entry;
      logic emit;
      logic emit_reject;
      logic emit_last;
      logic shift_byte;
      logic count_step;
      logic div_init;
      logic div_step;
      logic update;
      logic restore;
   } cmd_type;

   typedef struct packed {
      logic zero_freq;
      logic above_bound;
      logic slot_free;
      logic div_done;
      logic fin_last;
   } stat_type;

endpackage

// ===== rtl/core/rbe_datapath.sv =====
// ----------------------------------------------------------------------------
// rANS byte encoder datapath
// Symbol table, coder state, serial divider and the output beat register.
// ----------------------------------------------------------------------------
module rbe_datapath (
   input  logic            clock,
   input  logic            reset,
   input  rbe_pkg::req_type  req_data,
   input  rbe_pkg::cmd_type  cmd,
   output rbe_pkg::stat_type stat,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rbe_pkg::rsp_type  rsp_data
);
   import rbe_pkg::*;

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [ENTRY_W-1:0] rd_ff;
   logic               rd_valid_ff;
   logic               in_range;

   logic [STATE_W-1:0] x_ff, x_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [FREQ_W-1:0]  freq_ff, freq_in;
   logic [START_W-1:0] start_ff, start_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CMP_W-1:0]   bound;
   logic [REM_W-1:0]   rem_sh;
   logic               ge;

   assign in_range = SYM_CMP_W'(req_data.symbol) < SYM_CMP_W'(ALPHABET);

   always_ff @(posedge clock) begin
      if (cmd.table_write && in_range) begin
         mem[req_data.symbol] <= {req_data.frequency, req_data.start_req};
      end
      if (cmd.capture) begin
         rd_ff <= mem[req_data.symbol];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.table_write && in_range) begin
         valid_in[req_data.symbol] = 1'b1;
      end
   end

   assign bound  = CMP_W'(freq_ff) << BOUND_SHIFT;
   assign rem_sh = {rem_ff[REM_W-2:0], x_ff[STATE_W-1]};
   assign ge     = rem_sh >= REM_W'(freq_ff);

   always_comb begin
      x_in     = x_ff;
      rem_in   = rem_ff;
      freq_in  = freq_ff;
      start_in = start_ff;
      count_in = count_ff;
      if (cmd.latch_entry) begin
         freq_in  = rd_valid_ff ? rd_ff[ENTRY_W-1:START_W] : '0;
         start_in = rd_ff[START_W-1:0];
      end
      if (cmd.capture || cmd.div_init) begin
         count_in = '0;
      end else if (cmd.count_step) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.div_init) begin
         rem_in = '0;
      end
      if (cmd.shift_byte) begin
         x_in = x_ff >> BYTE_W;
      end
      if (cmd.div_step) begin
         rem_in = ge ? rem_sh - REM_W'(freq_ff) : rem_sh;
         x_in   = {x_ff[STATE_W-2:0], ge};
      end
      if (cmd.update) begin
         x_in = (x_ff << SCALE_BITS) + STATE_W'(rem_ff) + STATE_W'(start_ff);
      end
      if (cmd.restore) begin
         x_in = LOWER_BOUND;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in    = 1'b1;
         rsp_in.out_byte = cmd.emit_reject ? '0 : x_ff[BYTE_W-1:0];
         rsp_in.status   = cmd.emit_reject;
         rsp_in.last     = cmd.emit_last;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      freq_ff  <= freq_in;
      start_ff <= start_in;
      count_ff <= count_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         valid_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         x_ff         <= LOWER_BOUND;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         x_ff         <= x_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.capture) begin
            rd_valid_ff <= valid_ff[req_data.symbol] && in_range;
         end
      end
   end

   assign stat.zero_freq   = freq_ff == '0;
   assign stat.above_bound = CMP_W'(x_ff) >= bound;
   assign stat.slot_free   = !rsp_valid_ff || rsp_ready;
   assign stat.div_done    = count_ff == CNT_W'(DIV_STEPS - 1);
   assign stat.fin_last    = count_ff[FIN_W-1:0] == FIN_W'(FIN_BYTES - 1);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/rbe_ctrl.sv =====
// ----------------------------------------------------------------------------
// rANS byte encoder controller
// Sequences table loads, renormalization, the serial divide and finish runs.
// ----------------------------------------------------------------------------
module rbe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_action,
   input  rbe_pkg::stat_type stat,
   output rbe_pkg::cmd_type  cmd
);
   import rbe_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOOKUP = 6'b000010,
      ST_RENORM = 6'b000100,
      ST_DIVIDE = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_action)
                  ACT_LOAD:   cmd.table_write = 1'b1;
                  ACT_ENCODE: state_in = ST_LOOKUP;
                  ACT_FINISH: state_in = ST_FINISH;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOKUP: begin
            cmd.latch_entry = 1'b1;
            state_in        = ST_RENORM;
         end
         ST_RENORM: begin
            if (stat.zero_freq) begin
               if (stat.slot_free) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_reject = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else if (stat.above_bound) begin
               if (stat.slot_free) begin
                  cmd.emit       = 1'b1;
                  cmd.shift_byte = 1'b1;
               end
            end else begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step   = 1'b1;
            cmd.count_step = 1'b1;
            if (stat.div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_FINISH: begin
            if (stat.slot_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_last  = stat.fin_last;
               cmd.shift_byte = 1'b1;
               cmd.count_step = 1'b1;
               if (stat.fin_last) begin
                  cmd.restore = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/rans_byte_encoder.sv =====
// ----------------------------------------------------------------------------
// rANS byte encoder
// Byte-wise rANS encoder with a 32-bit state and a 256-entry symbol table.
// ----------------------------------------------------------------------------
// A load beat writes its table entry as it is accepted. An encode beat is
// accepted, reads the symbol table, emits any renormalization bytes one at a
// time, runs a bit-serial divide that yields quotient and remainder, and then
// updates the state. A zero-frequency symbol gives a rejection beat instead.
// A finish beat emits the four bytes of the state. No new request is taken
// until the encoder is back in idle. Output beats wait in a register, so a
// stalled consumer only holds the block when another byte is ready to leave.
module rans_byte_encoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rbe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rbe_pkg::rsp_type rsp_data
);
   import rbe_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rbe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_data.action),
      .stat       (stat),
      .cmd        (cmd)
   );

   rbe_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/rbe_stream_checker.sv =====
// ----------------------------------------------------------------------------
// rANS byte encoder stream checker
// Watches the request and result channels of the encoder. It keeps its own
// copy of the coder state and the symbol table, works out the byte beats that
// every accepted request must produce, and compares each accepted result beat
// against the oldest of them. It reports the failure count and the number of
// result beats still awaited.
// ----------------------------------------------------------------------------
module rbe_stream_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  rbe_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rbe_pkg::rsp_type rsp_data,
   output int               fails,
   output int               outstanding,
   output int               bytes_seen,
   output int               rejects_seen,
   output int               blocks_seen
);

   timeunit 1ns;
   timeprecision 1ps;

   import rbe_pkg::*;

   localparam int REPORT_LIMIT = 10;

   logic [STATE_W-1:0] coder_x;
   logic [FREQ_W-1:0]  freq_mem  [TABLE_DEPTH];
   logic [START_W-1:0] start_mem [TABLE_DEPTH];
   rsp_type            pending_bytes [$];

   int fail_total   = 0;
   int byte_total   = 0;
   int reject_total = 0;
   int block_total  = 0;

   function automatic rsp_type make_rsp(input logic [BYTE_W-1:0] b, input logic st,
                                        input logic lst);
      rsp_type r;
      r.out_byte = b;
      r.status   = st;
      r.last     = lst;
      return r;
   endfunction

   task automatic encode_beat(input req_type beat);
      logic [63:0] x;
      logic [63:0] bound;
      logic [63:0] f64;
      logic [63:0] s64;
      int          guard;
      f64 = '0;
      s64 = '0;
      if (int'(beat.symbol) < ALPHABET) begin
         f64 = 64'(freq_mem[beat.symbol]);
         s64 = 64'(start_mem[beat.symbol]);
      end
      if (f64 == 0) begin
         pending_bytes.push_back(make_rsp('0, 1'b1, 1'b0));
      end else begin
         bound = 64'(LOWER_BOUND) >> SCALE_BITS;
         bound = (bound << BYTE_W) * f64;
         x = 64'(coder_x);
         for (guard = 0; guard < 4 && x >= bound; guard++) begin
            pending_bytes.push_back(make_rsp(x[BYTE_W-1:0], 1'b0, 1'b0));
            x = x >> BYTE_W;
         end
         x = ((x / f64) << SCALE_BITS) + (x % f64) + s64;
         coder_x = x[STATE_W-1:0];
      end
   endtask

   task automatic predict_beat(input req_type beat);
      int k;
      case (beat.action)
         ACT_LOAD: begin
            if (int'(beat.symbol) < ALPHABET) begin
               freq_mem[beat.symbol]  = beat.frequency;
               start_mem[beat.symbol] = beat.start_req;
            end
         end
         ACT_ENCODE: begin
            encode_beat(beat);
         end
         ACT_FINISH: begin
            for (k = 0; k < FIN_BYTES; k++) begin
               pending_bytes.push_back(make_rsp(coder_x[k*BYTE_W +: BYTE_W], 1'b0,
                                                k == FIN_BYTES - 1));
            end
            coder_x = LOWER_BOUND;
         end
         default: ;
      endcase
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (got.status) reject_total++;
      else byte_total++;
      if (got.last) block_total++;
      if (pending_bytes.size() == 0) begin
         fail_total++;
         if (fail_total <= REPORT_LIMIT)
            $display("%0t: unexpected result beat byte %02h status %0b last %0b",
                     $time, got.out_byte, got.status, got.last);
      end else begin
         want = pending_bytes.pop_front();
         if (got.out_byte !== want.out_byte || got.status !== want.status ||
             got.last !== want.last) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
               $display("%0t: mismatch, expected %02h/%0b/%0b got %02h/%0b/%0b",
                        $time, want.out_byte, want.status, want.last,
                        got.out_byte, got.status, got.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         coder_x = LOWER_BOUND;
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            freq_mem[k]  = '0;
            start_mem[k] = '0;
         end
         pending_bytes.delete();
      end else begin
         if (req_valid && req_ready) predict_beat(req_data);
         if (rsp_valid && rsp_ready) check_beat(rsp_data);
      end
      fails        <= fail_total;
      outstanding  <= pending_bytes.size();
      bytes_seen   <= byte_total;
      rejects_seen <= reject_total;
      blocks_seen  <= block_total;
   end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// rANS byte encoder testbench
// Drives table loads, symbol encodes and block finishes into the encoder with
// random gaps and random result stalls. A directed opening covers field
// extremes, zero-frequency symbols, renormalization and the unused action;
// the random part loads normalized symbol tables and encodes streams over
// them, mixed with stray loads and symbols. The stream checker compares every
// result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import rbe_pkg::*;

   localparam logic [1:0] ACT_UNUSED   = 2'd3;
   localparam int         TARGET_ITEMS = 280;
   localparam int         IDLE_LIMIT   = 5000;
   localparam int         DRAIN_CYCLES = 80;
   localparam int         MAX_WAIT     = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fails;
   int outstanding;
   int bytes_seen;
   int rejects_seen;
   int blocks_seen;

   int items_sent  = 0;
   int idle_cycles = 0;
   int rx_stall    = 0;
   bit tx_calm     = 1'b0;
   bit rx_calm     = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rans_byte_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rbe_stream_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .fails        (fails),
      .outstanding  (outstanding),
      .bytes_seen   (bytes_seen),
      .rejects_seen (rejects_seen),
      .blocks_seen  (blocks_seen)
   );

   // After each result beat the receiver draws a random stall, or none while in its calm phase.
   always @(posedge clock) begin
      if (reset) begin
         rx_stall = 0;
      end else if (rsp_valid && rsp_ready) begin
         if ($urandom_range(0, 15) == 0) rx_calm = !rx_calm;
         rx_stall = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (rx_stall > 0) begin
         rx_stall--;
      end
      rsp_ready <= !reset && rx_stall == 0;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT - 1) begin
         $display("Watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("FAIL rans_byte_encoder");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_beat(input logic [1:0] act, input logic [SYM_W-1:0] sym,
                                         input logic [FREQ_W-1:0] f,
                                         input logic [START_W-1:0] s);
      req_type b;
      b.action    = act;
      b.symbol    = sym;
      b.frequency = f;
      b.start_req = s;
      return b;
   endfunction

   task automatic send_beat(input req_type beat);
      int gap;
      if ($urandom_range(0, 15) == 0) tx_calm = !tx_calm;
      gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      if (beat.action != ACT_UNUSED) items_sent++;
   endtask

   task automatic send_noise(input logic [1:0] act);
      send_beat(make_beat(act, SYM_W'($urandom_range(0, 255)),
                          FREQ_W'($urandom_range(0, 8191)),
                          START_W'($urandom_range(0, 4095))));
   endtask

   task automatic send_symbol(input logic [1:0] act, input logic [SYM_W-1:0] sym);
      send_beat(make_beat(act, sym, FREQ_W'($urandom_range(0, 8191)),
                          START_W'($urandom_range(0, 4095))));
   endtask

   initial begin
      logic [SYM_W-1:0] chosen [16];
      int               n_syms;
      int               n_codes;
      int               remaining;
      int               cum;
      int               f;
      int               pick;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_symbol(ACT_ENCODE, 8'h00);
      send_symbol(ACT_ENCODE, 8'hFF);
      send_beat(make_beat(ACT_UNUSED, 8'hFF, 13'h1FFF, 12'hFFF));
      send_symbol(ACT_FINISH, 8'h00);
      send_beat(make_beat(ACT_LOAD, 8'hFF, 13'd4096, 12'd0));
      send_beat(make_beat(ACT_LOAD, 8'h00, 13'd1, 12'hFFF));
      send_beat(make_beat(ACT_LOAD, 8'hAA, 13'h1FFF, 12'hAAA));
      send_beat(make_beat(ACT_LOAD, 8'h55, 13'd1365, 12'h555));
      send_symbol(ACT_ENCODE, 8'hFF);
      repeat (4) send_symbol(ACT_ENCODE, 8'h00);
      send_symbol(ACT_ENCODE, 8'hAA);
      send_symbol(ACT_ENCODE, 8'h55);
      send_beat(make_beat(ACT_UNUSED, 8'h00, 13'h0000, 12'h000));
      send_beat(make_beat(ACT_LOAD, 8'h55, 13'd0, 12'd0));
      send_symbol(ACT_ENCODE, 8'h55);
      send_symbol(ACT_FINISH, 8'hFF);
      send_symbol(ACT_ENCODE, 8'h00);
      send_symbol(ACT_FINISH, 8'h00);

      while (items_sent < TARGET_ITEMS) begin
         n_syms    = $urandom_range(2, 16);
         remaining = 1 << SCALE_BITS;
         cum       = 0;
         for (int i = 0; i < n_syms; i++) begin
            chosen[i] = SYM_W'($urandom_range(0, 255));
            if (i == n_syms - 1) f = remaining;
            else f = $urandom_range(1, (remaining - (n_syms - 1 - i) + 1) / 2);
            send_beat(make_beat(ACT_LOAD, chosen[i], FREQ_W'(f), START_W'(cum)));
            cum       += f;
            remaining -= f;
         end
         n_codes = $urandom_range(4, 24);
         for (int j = 0; j < n_codes; j++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) send_noise(ACT_ENCODE);
            else if (pick == 1) send_noise(ACT_UNUSED);
            else if (pick == 2) send_noise(ACT_LOAD);
            else send_symbol(ACT_ENCODE, chosen[$urandom_range(0, n_syms - 1)]);
         end
         if ($urandom_range(0, 4) != 0) begin
            send_symbol(ACT_FINISH, SYM_W'($urandom_range(0, 255)));
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request beats; received %0d byte beats and %0d rejections.",
               items_sent, bytes_seen, rejects_seen);
      $display("Finished blocks seen: %0d; failures counted: %0d.", blocks_seen, fails);
      if (fails == 0 && outstanding == 0) begin
         $display("PASS rans_byte_encoder");
      end else begin
         $display("FAIL rans_byte_encoder");
      end
      $finish;
   end

endmodule
